@@ design/fb_pkg.sv @@
// ----------------------------------------------------------------------------
// fb_pkg: shared types and constants for the IPv4 UDP/TCP frame builder
// Request, result and job payload structs, frame layout constants and
// configuration register indexes.
// ----------------------------------------------------------------------------
package fb_pkg;

    localparam int FRAME_BYTES = 62;
    localparam int IDX_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TTL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;

    localparam logic [7:0]  TTL_RESET    = 8'h80;
    localparam logic [15:0] WINDOW_RESET = 16'h0100;

    localparam logic [7:0]  PROTO_UDP     = 8'h11;
    localparam logic [7:0]  PROTO_TCP     = 8'h06;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_TOTAL_LEN  = 8'h28;
    localparam logic [7:0]  IP_FLAGS_DF   = 8'h40;
    localparam logic [7:0]  ETHERTYPE_HI  = 8'h08;
    localparam logic [7:0]  TCP_DATA_OFS  = 8'h50;
    localparam logic [7:0]  SEG_LEN       = 8'h14;
    // 0x4500 + 0x0028 + 0x4000: fixed words of the IPv4 header
    localparam logic [15:0] IP_FIXED_SUM  = 16'h8528;
    localparam logic [15:0] TCP_OFS_WORD  = 16'h5000;
    localparam logic [15:0] UDP_LEN_WORD  = 16'h0014;

    typedef struct packed {
        logic        req_type;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } req_t;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [IDX_W-1:0] byte_index;
        logic             last_byte;
    } res_t;

    // one classified request, ready to be serialized
    typedef struct packed {
        req_t        req;
        logic [7:0]  ttl;
        logic [15:0] window;
        logic [15:0] ip_csum;
        logic [15:0] seg_csum;
    } job_t;

endpackage

@@ design/fb_front.sv @@
// ----------------------------------------------------------------------------
// fb_front: request capture and checksum pipeline
// Three stages: capture, partial word sums, full sums; the ones'-complement
// fold feeds the job queue.
// ----------------------------------------------------------------------------
module fb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  fb_pkg::req_t  in_data,
    input  logic [7:0]    ttl,
    input  logic [15:0]   window,
    output logic          push_valid,
    input  logic          push_ready,
    output fb_pkg::job_t  push_data
);
    import fb_pkg::*;

    function automatic logic [15:0] fold_csum(input logic [18:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        begin
            s1 = 17'(s[15:0]) + 17'(s[18:16]);
            s2 = 17'(s1[15:0]) + 17'(s1[16]);
            return ~s2[15:0];
        end
    endfunction

    logic        a_valid_reg;
    req_t        a_req_reg;
    logic [7:0]  a_ttl_reg;
    logic [15:0] a_win_reg;

    logic        b_valid_reg;
    req_t        b_req_reg;
    logic [7:0]  b_ttl_reg;
    logic [15:0] b_win_reg;
    logic [17:0] b_addr_sum_reg;
    logic [16:0] b_port_sum_reg;

    logic        c_valid_reg;
    req_t        c_req_reg;
    logic [7:0]  c_ttl_reg;
    logic [15:0] c_win_reg;
    logic [18:0] c_ip_raw_reg;
    logic [18:0] c_seg_raw_reg;

    logic        a_adv, b_adv, c_adv;
    logic [7:0]  b_proto;
    logic [16:0] b_seg_tail;
    logic [15:0] seg_fold;

    assign c_adv    = !c_valid_reg || push_ready;
    assign b_adv    = !b_valid_reg || c_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_stall = !a_adv;

    assign b_proto    = b_req_reg.req_type ? PROTO_TCP : PROTO_UDP;
    assign b_seg_tail = b_req_reg.req_type ? 17'(TCP_OFS_WORD) + 17'(b_win_reg)
                                           : 17'(UDP_LEN_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= in_valid;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
            if (c_adv)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
        begin
            a_req_reg <= in_data;
            a_ttl_reg <= ttl;
            a_win_reg <= window;
        end
        if (b_adv && a_valid_reg)
        begin
            b_req_reg      <= a_req_reg;
            b_ttl_reg      <= a_ttl_reg;
            b_win_reg      <= a_win_reg;
            b_addr_sum_reg <= 18'(a_req_reg.src_ip[31:16]) + 18'(a_req_reg.src_ip[15:0])
                            + 18'(a_req_reg.dst_ip[31:16]) + 18'(a_req_reg.dst_ip[15:0]);
            b_port_sum_reg <= 17'(a_req_reg.src_port) + 17'(a_req_reg.dst_port);
        end
        if (c_adv && b_valid_reg)
        begin
            c_req_reg     <= b_req_reg;
            c_ttl_reg     <= b_ttl_reg;
            c_win_reg     <= b_win_reg;
            c_ip_raw_reg  <= 19'(b_addr_sum_reg) + 19'({b_ttl_reg, b_proto})
                           + 19'(IP_FIXED_SUM);
            // pseudo-header protocol and length, then the segment words
            c_seg_raw_reg <= 19'(b_addr_sum_reg) + 19'(b_port_sum_reg) + 19'(b_proto)
                           + 19'(SEG_LEN) + 19'(b_seg_tail);
        end
    end

    assign seg_fold = fold_csum(c_seg_raw_reg);

    always_comb
    begin
        push_data.req     = c_req_reg;
        push_data.ttl     = c_ttl_reg;
        push_data.window  = c_win_reg;
        push_data.ip_csum = fold_csum(c_ip_raw_reg);
        // UDP reserves zero for "no checksum"
        if (!c_req_reg.req_type && seg_fold == 16'h0000)
            push_data.seg_csum = 16'hffff;
        else
            push_data.seg_csum = seg_fold;
    end

    assign push_valid = c_valid_reg;

endmodule

@@ design/fb_queue.sv @@
// ----------------------------------------------------------------------------
// fb_queue: two-entry job queue
// Shift-style queue between the checksum pipeline and the serializer; the
// head always sits in slot 0.
// ----------------------------------------------------------------------------
module fb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  fb_pkg::job_t  push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output fb_pkg::job_t  pop_data
);
    import fb_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    job_t       slot0_reg;
    job_t       slot1_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot0_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && count_reg == 2'd1)
                slot0_reg <= push_data;
            else
                slot0_reg <= slot1_reg;
            if (push && count_reg == 2'd2)
                slot1_reg <= push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                slot0_reg <= push_data;
            else
                slot1_reg <= push_data;
        end
    end

endmodule

@@ design/fb_back.sv @@
// ----------------------------------------------------------------------------
// fb_back: frame serializer
// Takes one job from the queue and emits its frame one byte per transfer
// through a registered output stage.
// ----------------------------------------------------------------------------
module fb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  fb_pkg::job_t  job_data,
    output logic          out_valid,
    input  logic          out_stall,
    output fb_pkg::res_t  out_data
);
    import fb_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    function automatic logic [7:0] frame_byte_at(input job_t j, input logic [IDX_W-1:0] idx);
        logic       tcp;
        logic [7:0] b;
        begin
            tcp = j.req.req_type;
            b   = 8'h00;
            unique case (idx)
                6'd0:  b = j.req.dst_mac[47:40];
                6'd1:  b = j.req.dst_mac[39:32];
                6'd2:  b = j.req.dst_mac[31:24];
                6'd3:  b = j.req.dst_mac[23:16];
                6'd4:  b = j.req.dst_mac[15:8];
                6'd5:  b = j.req.dst_mac[7:0];
                6'd6:  b = j.req.src_mac[47:40];
                6'd7:  b = j.req.src_mac[39:32];
                6'd8:  b = j.req.src_mac[31:24];
                6'd9:  b = j.req.src_mac[23:16];
                6'd10: b = j.req.src_mac[15:8];
                6'd11: b = j.req.src_mac[7:0];
                6'd12: b = ETHERTYPE_HI;
                6'd14: b = IP_VER_IHL;
                6'd17: b = IP_TOTAL_LEN;
                6'd20: b = IP_FLAGS_DF;
                6'd22: b = j.ttl;
                6'd23: b = tcp ? PROTO_TCP : PROTO_UDP;
                6'd24: b = j.ip_csum[15:8];
                6'd25: b = j.ip_csum[7:0];
                6'd26: b = j.req.src_ip[31:24];
                6'd27: b = j.req.src_ip[23:16];
                6'd28: b = j.req.src_ip[15:8];
                6'd29: b = j.req.src_ip[7:0];
                6'd30: b = j.req.dst_ip[31:24];
                6'd31: b = j.req.dst_ip[23:16];
                6'd32: b = j.req.dst_ip[15:8];
                6'd33: b = j.req.dst_ip[7:0];
                6'd34: b = j.req.src_port[15:8];
                6'd35: b = j.req.src_port[7:0];
                6'd36: b = j.req.dst_port[15:8];
                6'd37: b = j.req.dst_port[7:0];
                6'd39: b = tcp ? 8'h00 : SEG_LEN;
                6'd40: b = tcp ? 8'h00 : j.seg_csum[15:8];
                6'd41: b = tcp ? 8'h00 : j.seg_csum[7:0];
                6'd46: b = tcp ? TCP_DATA_OFS : 8'h00;
                6'd48: b = tcp ? j.window[15:8] : 8'h00;
                6'd49: b = tcp ? j.window[7:0] : 8'h00;
                6'd50: b = tcp ? j.seg_csum[15:8] : 8'h00;
                6'd51: b = tcp ? j.seg_csum[7:0] : 8'h00;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    logic             busy_reg;
    job_t             job_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             out_valid_reg;
    res_t             out_data_reg;

    logic out_free, emit, finish, take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && out_free;
    assign finish    = emit && (cnt_reg == LAST_IDX);
    // next job loads in the same cycle the last byte leaves
    assign job_ready = !busy_reg || finish;
    assign take      = job_valid && job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= emit;
            if (take)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (finish)
                busy_reg <= 1'b0;
            else if (emit)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_data;
        if (emit)
        begin
            out_data_reg.frame_byte <= frame_byte_at(job_reg, cnt_reg);
            out_data_reg.byte_index <= cnt_reg;
            out_data_reg.last_byte  <= (cnt_reg == LAST_IDX);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ design/ipv4_udp_tcp_frame_builder.sv @@
// ----------------------------------------------------------------------------
// ipv4_udp_tcp_frame_builder: Ethernet/IPv4 frame builder, UDP or TCP
// Builds one fixed-size frame per request with IPv4 header and segment
// checksums; holds the TTL and TCP window registers.
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_stall  fb_pkg::req_t, one request
//   out_*        out  out_valid/out_stall fb_pkg::res_t, one frame byte
//   cfg_*        in   cfg_we             cfg_index, cfg_data
//
// Each request streams out as FRAME_BYTES (62) byte transfers from the
// byte-wide serializer, which takes a new job only as a frame's last byte
// leaves. A request passes capture, both sum stages, the queue and output.
// Up to five requests wait (three in the capture/sum pipeline, two in the
// job queue) behind the frame being serialized while the output is stalled.
// Reset clears all control state and loads TTL 128 and window 256.
// ----------------------------------------------------------------------------
module ipv4_udp_tcp_frame_builder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  fb_pkg::req_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output fb_pkg::res_t                      out_data,
    input  logic                              cfg_we,
    input  logic [fb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fb_pkg::*;

    logic [7:0]  ttl_reg;
    logic [15:0] window_reg;

    logic push_valid, push_ready;
    job_t push_data;
    logic job_valid, job_ready;
    job_t job_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg    <= TTL_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TTL)
                ttl_reg <= cfg_data[7:0];
            else if (cfg_index == CFG_WINDOW)
                window_reg <= cfg_data[15:0];
        end
    end

    fb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .ttl        (ttl_reg),
        .window     (window_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    fb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_data   (job_data)
    );

    fb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job_data   (job_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
